// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the Sobol point generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SPG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spg assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define SPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spg assertion failed");

`endif

// ===== rtl/spg_pkg.sv =====
// Package of types, constants and polynomial tables for the Sobol point generator.
`default_nettype none

package spg_pkg;

    localparam int DIR_BITS      = 32;
    localparam int ROW_W         = DIR_BITS * DIR_BITS;
    localparam int MAX_DIMENSION = 10;
    localparam int POLY_COUNT    = 9;
    localparam int MAX_DEGREE    = 5;
    localparam int COORD_W       = 4;
    localparam int DIM_W         = 4;
    localparam int BIT_W         = 5;

    localparam logic [2:0] POLY_DEGREE [POLY_COUNT] = '{
        3'd1, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
    };

    localparam logic [3:0] POLY_COEFF [POLY_COUNT] = '{
        4'd0, 4'd1, 4'd1, 4'd2, 4'd1, 4'd4, 4'd2, 4'd4, 4'd7
    };

    localparam logic [4:0] POLY_INIT [POLY_COUNT][MAX_DEGREE] = '{
        '{5'd1, 5'd0, 5'd0, 5'd0,  5'd0},
        '{5'd1, 5'd3, 5'd0, 5'd0,  5'd0},
        '{5'd1, 5'd3, 5'd1, 5'd0,  5'd0},
        '{5'd1, 5'd1, 5'd1, 5'd0,  5'd0},
        '{5'd1, 5'd3, 5'd5, 5'd13, 5'd0},
        '{5'd1, 5'd1, 5'd5, 5'd5,  5'd0},
        '{5'd1, 5'd3, 5'd3, 5'd9,  5'd7},
        '{5'd1, 5'd1, 5'd5, 5'd11, 5'd27},
        '{5'd1, 5'd1, 5'd7, 5'd13, 5'd3}
    };

    typedef enum logic {
        ST_FILL,
        ST_DONE
    } t_fill_state;

    typedef struct packed {
        logic               done;
        logic               we;
        logic [COORD_W-1:0] addr;
        logic [ROW_W-1:0]   data;
    } t_fill_wr;

endpackage

`default_nettype wire

// ===== rtl/sobol_point_generator_core.sv =====
// Top level of the Sobol point generator: command port, table memory and coordinate pipeline.
//
// After reset the block builds its direction-word table, one word per cycle; busy
// stays high throughout. From then on a point index is taken when start is high and
// busy is low, and the point is delivered as one word per coordinate on consecutive
// cycles, one table-memory read per coordinate; the number of coordinates is the
// configured dimension, clamped to 1 to MAX_DIMENSION. The next index is taken in the
// cycle that the previous point issues its last coordinate, so points stream without
// gaps. The first word of a point passes through the coordinate register, the
// table-memory read register and the output register. Results are strobed by
// o_valid for a single cycle and cannot be held off by the receiver.
`default_nettype none

`include "assert_macros.svh"

module sobol_point_generator_core #(
    parameter int MAX_DIMENSION = spg_pkg::MAX_DIMENSION
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [spg_pkg::DIM_W-1:0]    i_cfg_wdata,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [spg_pkg::DIR_BITS-1:0] i_point_index,
    output logic                              o_valid,
    output logic [spg_pkg::COORD_W-1:0]       o_coordinate_number,
    output logic [spg_pkg::DIR_BITS-1:0]      o_coordinate_value,
    output logic                              o_last_coordinate
);

    localparam int DW     = spg_pkg::DIR_BITS;
    localparam int RW     = spg_pkg::ROW_W;
    localparam int CW     = spg_pkg::COORD_W;
    localparam int ADDR_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

    spg_pkg::t_fill_wr fill;
    logic [RW-1:0]     ram_rdata;

    logic [spg_pkg::DIM_W-1:0] r_dimension;
    logic [CW-1:0]             count_sat;

    logic          r_active;
    logic [CW-1:0] r_coord;
    logic [CW-1:0] r_count;
    logic [DW-1:0] r_gray;
    logic          issue_last;
    logic          accept;

    logic          r_b_valid;
    logic [CW-1:0] r_b_coord;
    logic          r_b_last;
    logic [DW-1:0] r_b_gray;
    logic [DW-1:0] n_value;

    logic          r_valid;
    logic [CW-1:0] r_out_coord;
    logic [DW-1:0] r_out_value;
    logic          r_out_last;

    spg_dir_fill #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_fill (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .o_fill (fill)
    );

    spg_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_DIMENSION)
    ) u_dir_ram (
        .i_clk  (i_clk),
        .i_we   (fill.we),
        .i_waddr(fill.addr[ADDR_W-1:0]),
        .i_wdata(fill.data),
        .i_raddr(r_coord[ADDR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= spg_pkg::DIM_W'(1);
        end else if (i_cfg_we) begin
            r_dimension <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_dimension == '0) begin
            count_sat = CW'(1);
        end else if (r_dimension > spg_pkg::DIM_W'(MAX_DIMENSION)) begin
            count_sat = CW'(MAX_DIMENSION);
        end else begin
            count_sat = CW'(r_dimension);
        end
    end

    assign issue_last = r_active && (r_coord == CW'(r_count - 1'b1));
    assign busy       = !fill.done || (r_active && !issue_last);
    assign accept     = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_coord  <= '0;
        end else if (accept) begin
            r_active <= 1'b1;
            r_coord  <= '0;
        end else if (issue_last) begin
            r_active <= 1'b0;
            r_coord  <= '0;
        end else if (r_active) begin
            r_coord <= CW'(r_coord + 1'b1);
        end
        if (accept) begin
            r_count <= count_sat;
            r_gray  <= i_point_index ^ (i_point_index >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_active;
        end
        r_b_coord <= r_coord;
        r_b_last  <= issue_last;
        r_b_gray  <= r_gray;
    end

    always_comb begin
        n_value = '0;
        for (int b = 0; b < DW; b++) begin
            if (r_b_gray[b]) begin
                n_value = n_value ^ ram_rdata[b*DW +: DW];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_b_valid;
        end
        r_out_coord <= r_b_coord;
        r_out_value <= n_value;
        r_out_last  <= r_b_last;
    end

    assign o_valid             = r_valid;
    assign o_coordinate_number = r_out_coord;
    assign o_coordinate_value  = r_out_value;
    assign o_last_coordinate   = r_out_last;

    `SPG_ASSERT_NOW(a_accept_only_at_end, i_clk, i_rst_n, accept && r_active, issue_last)
    `SPG_ASSERT_NOW(a_no_word_before_table, i_clk, i_rst_n, r_active || r_valid, fill.done)
    `SPG_ASSERT_NEXT(a_point_contiguous, i_clk, i_rst_n,
        r_b_valid && !r_b_last, r_b_valid && (r_b_coord == CW'($past(r_b_coord) + 1'b1)))

endmodule

`default_nettype wire

// ===== rtl/spg_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module spg_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/spg_dir_fill.sv =====
// Sequencer that builds the direction-word table row by row after reset.
`default_nettype none

`include "assert_macros.svh"

module spg_dir_fill #(
    parameter int MAX_DIMENSION = spg_pkg::MAX_DIMENSION
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    output spg_pkg::t_fill_wr o_fill
);

    localparam int DW = spg_pkg::DIR_BITS;
    localparam int RW = spg_pkg::ROW_W;
    localparam int CW = spg_pkg::COORD_W;
    localparam int BW = spg_pkg::BIT_W;

    spg_pkg::t_fill_state r_state;
    spg_pkg::t_fill_state n_state;
    logic [CW-1:0]        r_c;
    logic [CW-1:0]        n_c;
    logic [BW-1:0]        r_b;
    logic [BW-1:0]        n_b;
    logic [RW-1:0]        r_row;
    logic [RW-1:0]        n_row;

    logic                 use_vdc;
    logic [3:0]           pidx;
    logic [2:0]           s;
    logic [3:0]           coeff;
    logic [DW-1:0]        hist [spg_pkg::MAX_DEGREE];
    logic [DW-1:0]        word;
    logic                 row_end;
    logic                 we;

    always_comb begin
        use_vdc = (r_c == '0) || (r_c > CW'(spg_pkg::POLY_COUNT));
        pidx    = use_vdc ? 4'd0 : 4'(r_c - 1'b1);
        s       = spg_pkg::POLY_DEGREE[pidx];
        coeff   = spg_pkg::POLY_COEFF[pidx];
        for (int k = 0; k < spg_pkg::MAX_DEGREE; k++) begin
            hist[k] = r_row[RW-1-k*DW -: DW];
        end
    end

    always_comb begin
        logic [4:0]    m;
        logic [DW-1:0] rec;
        logic [2:0]    sh;
        m   = '0;
        rec = '0;
        sh  = '0;
        if (use_vdc) begin
            word = 32'h8000_0000 >> r_b;
        end else if (r_b < {2'b00, s}) begin
            m    = spg_pkg::POLY_INIT[pidx][r_b[2:0]];
            word = {27'd0, m} << (5'd31 - r_b);
        end else begin
            rec = hist[3'(s - 3'd1)];
            rec = rec ^ (rec >> s);
            for (int k = 1; k < spg_pkg::MAX_DEGREE; k++) begin
                sh = 3'(s - 3'(k) - 3'd1);
                if ((3'(k) < s) && coeff[sh[1:0]]) begin
                    rec = rec ^ hist[k-1];
                end
            end
            word = rec;
        end
    end

    always_comb begin
        n_state = r_state;
        n_c     = r_c;
        n_b     = r_b;
        n_row   = {word, r_row[RW-1:DW]};
        row_end = (r_b == BW'(DW - 1));
        we      = 1'b0;
        case (r_state)
            spg_pkg::ST_FILL: begin
                n_b = BW'(r_b + 1'b1);
                if (row_end) begin
                    we  = 1'b1;
                    n_c = CW'(r_c + 1'b1);
                    if (r_c == CW'(MAX_DIMENSION - 1)) begin
                        n_state = spg_pkg::ST_DONE;
                    end
                end
            end
            spg_pkg::ST_DONE: begin
                n_row = r_row;
            end
            default: begin
                n_state = spg_pkg::ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spg_pkg::ST_FILL;
            r_c     <= '0;
            r_b     <= '0;
        end else begin
            r_state <= n_state;
            r_c     <= n_c;
            r_b     <= n_b;
        end
        r_row <= n_row;
    end

    assign o_fill.done = (r_state == spg_pkg::ST_DONE);
    assign o_fill.we   = we;
    assign o_fill.addr = r_c;
    assign o_fill.data = n_row;

    `SPG_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n,
        r_state == spg_pkg::ST_DONE, r_state == spg_pkg::ST_DONE)
    `SPG_ASSERT_NOW(a_write_row_end, i_clk, i_rst_n, we, r_b == BW'(DW - 1))
    `SPG_ASSERT_NOW(a_write_addr_range, i_clk, i_rst_n, we, r_c < CW'(MAX_DIMENSION))

endmodule

`default_nettype wire

// ===== tb/tb_sobol_point_generator_core.sv =====
// Self-checking testbench for the Sobol point generator core.
`timescale 1ns / 1ps

module tb_sobol_point_generator_core;

    localparam int RANDOM_POINTS = 260;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 4;

    typedef enum logic [1:0] {
        CMD_POINT,
        CMD_DIM,
        CMD_DRAIN
    } t_host_op;

    typedef struct {
        t_host_op    op;
        logic [31:0] value;
    } t_host_cmd;

    typedef struct {
        logic [spg_pkg::COORD_W-1:0]  number;
        logic [spg_pkg::DIR_BITS-1:0] value;
        logic                         last;
    } t_coord_word;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_cfg_we      = 1'b0;
    logic [spg_pkg::DIM_W-1:0]    i_cfg_wdata   = '0;
    logic                         start         = 1'b0;
    logic [spg_pkg::DIR_BITS-1:0] i_point_index = '0;
    logic                         busy;
    logic                         o_valid;
    logic [spg_pkg::COORD_W-1:0]  o_coordinate_number;
    logic [spg_pkg::DIR_BITS-1:0] o_coordinate_value;
    logic                         o_last_coordinate;

    t_host_cmd   host_cmds[$];
    t_coord_word coordinate_words[$];
    logic [31:0] direction_rom [10][32];
    logic [3:0]  dim_setting  = 4'd1;
    int          fail_count   = 0;
    int          points_taken = 0;
    int          quiet_cycles = 0;
    int          cycle_count  = 0;

    const int          POLY_DEGREE_TB [9]    = '{1, 2, 3, 3, 4, 4, 5, 5, 5};
    const int          POLY_COEFF_TB  [9]    = '{0, 1, 1, 2, 1, 4, 2, 4, 7};
    const logic [31:0] POLY_INIT_TB   [9][5] = '{
        '{1, 0, 0, 0,  0},
        '{1, 3, 0, 0,  0},
        '{1, 3, 1, 0,  0},
        '{1, 1, 1, 0,  0},
        '{1, 3, 5, 13, 0},
        '{1, 1, 5, 5,  0},
        '{1, 3, 3, 9,  7},
        '{1, 1, 5, 11, 27},
        '{1, 1, 7, 13, 3}
    };

    sobol_point_generator_core DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .start               (start),
        .busy                (busy),
        .i_point_index       (i_point_index),
        .o_valid             (o_valid),
        .o_coordinate_number (o_coordinate_number),
        .o_coordinate_value  (o_coordinate_value),
        .o_last_coordinate   (o_last_coordinate)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] sobol_coordinate(input int coord, input logic [31:0] gray);
        logic [31:0] acc;
        acc = '0;
        for (int b = 0; b < 32; b++) begin
            if (gray[b]) begin
                acc ^= direction_rom[coord][b];
            end
        end
        return acc;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic add_cmd(input t_host_op op, input logic [31:0] value);
        t_host_cmd cmd;
        cmd.op    = op;
        cmd.value = value;
        host_cmds.insert(host_cmds.size(), cmd);
    endtask

    task automatic queue_point(input logic [31:0] idx);
        add_cmd(CMD_POINT, idx);
    endtask

    task automatic queue_dim(input logic [31:0] dim);
        add_cmd(CMD_DIM, dim);
    endtask

    // Driver: presents points and performs register writes once the block has gone quiet.
    always @(posedge i_clk) begin : driver
        logic                         next_start;
        logic                         next_we;
        logic [spg_pkg::DIR_BITS-1:0] next_index;
        logic [spg_pkg::DIM_W-1:0]    next_wdata;
        logic                         gap;
        t_host_cmd                    cmd;
        next_start = start;
        next_we    = 1'b0;
        next_index = i_point_index;
        next_wdata = i_cfg_wdata;
        if (i_rst_n) begin
            if (start && !busy) begin
                points_taken++;
            end
            if (!start && !busy && !i_cfg_we && coordinate_words.size() == 0) begin
                quiet_cycles++;
            end else begin
                quiet_cycles = 0;
            end
            if (!(start && busy)) begin
                next_start = 1'b0;
                gap = ($urandom_range(99) < 14) && !(points_taken >= 120 && points_taken < 180);
                if (host_cmds.size() != 0) begin
                    cmd = host_cmds[0];
                    case (cmd.op)
                        CMD_POINT: begin
                            if (!gap) begin
                                next_start = 1'b1;
                                next_index = cmd.value;
                                void'(host_cmds.pop_front());
                            end
                        end
                        CMD_DIM: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                next_we      = 1'b1;
                                next_wdata   = cmd.value[spg_pkg::DIM_W-1:0];
                                dim_setting  = cmd.value[3:0];
                                quiet_cycles = 0;
                                void'(host_cmds.pop_front());
                            end
                        end
                        default: begin
                            if (quiet_cycles >= SETTLE_CYCLES) begin
                                void'(host_cmds.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        start         <= next_start;
        i_cfg_we      <= next_we;
        i_point_index <= next_index;
        i_cfg_wdata   <= next_wdata;
    end

    // Monitor: checks each delivered word and records the words owed for each accepted point.
    always @(posedge i_clk) begin : monitor
        t_coord_word want;
        t_coord_word word;
        logic [31:0] gray;
        int          count;
        if (i_rst_n) begin
            if (o_valid) begin
                if (coordinate_words.size() == 0) begin
                    note_failure($sformatf("unexpected word: number %0d value %h last %0b",
                        o_coordinate_number, o_coordinate_value, o_last_coordinate));
                end else begin
                    want = coordinate_words.pop_front();
                    if (o_coordinate_number !== want.number
                            || o_coordinate_value !== want.value
                            || o_last_coordinate !== want.last) begin
                        note_failure($sformatf(
                            "word mismatch: expected %0d/%h/%0b, got %0d/%h/%0b",
                            want.number, want.value, want.last,
                            o_coordinate_number, o_coordinate_value, o_last_coordinate));
                    end
                end
            end
            if (start && !busy) begin
                gray  = i_point_index ^ (i_point_index >> 1);
                count = (dim_setting == 0) ? 1 : (dim_setting > 10) ? 10 : dim_setting;
                for (int c = 0; c < count; c++) begin
                    word.number = c[spg_pkg::COORD_W-1:0];
                    word.value  = sobol_coordinate(c, gray);
                    word.last   = (c == count - 1);
                    coordinate_words.insert(coordinate_words.size(), word);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        int          s;
        logic [31:0] v;
        logic [31:0] base;
        int          random_points;
        int          phase;
        int          run_len;

        // The first coordinate runs on the plain radix-two directions.
        for (int b = 0; b < 32; b++) begin
            direction_rom[0][b] = 32'h1 << (31 - b);
        end
        for (int c = 1; c < 10; c++) begin
            s = POLY_DEGREE_TB[c-1];
            for (int b = 0; b < s; b++) begin
                direction_rom[c][b] = POLY_INIT_TB[c-1][b] << (31 - b);
            end
            for (int b = s; b < 32; b++) begin
                v = direction_rom[c][b-s];
                v ^= v >> s;
                for (int k = 1; k < s; k++) begin
                    if ((POLY_COEFF_TB[c-1] >> (s - 1 - k)) & 1) begin
                        v ^= direction_rom[c][b-k];
                    end
                end
                direction_rom[c][b] = v;
            end
        end

        queue_point(32'd0);
        queue_point(32'd1);
        queue_point(32'hFFFF_FFFF);
        queue_dim(10);
        queue_point(32'd0);
        queue_point(32'd1);
        queue_point(32'd2);
        queue_point(32'd3);
        queue_point(32'hFFFF_FFFF);
        queue_point(32'h8000_0000);
        queue_point(32'hAAAA_AAAA);
        queue_point(32'h5555_5555);
        queue_point(32'h7FFF_FFFF);
        add_cmd(CMD_DRAIN, 32'd0);
        queue_point(32'd4);
        queue_dim(0);
        queue_point(32'd5);
        queue_point(32'hFFFF_FFFF);
        queue_dim(15);
        queue_point(32'd7);
        queue_point(32'hFFFF_FFFF);
        queue_dim(11);
        queue_point(32'd1);

        random_points = 0;
        phase         = 0;
        while (random_points < RANDOM_POINTS) begin
            case (phase % 4)
                0:       queue_dim(10);
                1:       queue_dim(1);
                default: queue_dim($urandom_range(15));
            endcase
            run_len = $urandom_range(15, 35);
            base    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(50);
            for (int n = 0; n < run_len; n++) begin
                if ($urandom_range(9) < 7) begin
                    queue_point(base);
                    base++;
                end else begin
                    queue_point($urandom);
                end
                if ($urandom_range(29) == 0) begin
                    add_cmd(CMD_DRAIN, 32'd0);
                end
                random_points++;
            end
            phase++;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (host_cmds.size() != 0 || start) @(posedge i_clk);
        while (coordinate_words.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
